// ===== src/mp2d_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared constants, register indexes and types of the 2-D max pooling block.
// ----------------------------------------------------------------------------
package mp2d_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_POOL   = 8;
    localparam int DEF_DATA_WIDTH = 16;

    localparam int ROW_W        = 10;
    localparam int OUT_IDX_W    = 10;
    localparam int DIM_W        = 11;
    localparam int STEP_W       = 4;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 11;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_HEIGHT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_WIDTH  = CFG_IDX_W'(3);

    localparam logic [STEP_W-1:0] RST_WINDOW_SIZE  = STEP_W'(2);
    localparam logic [STEP_W-1:0] RST_STEP_SIZE    = STEP_W'(2);
    localparam logic [DIM_W-1:0]  RST_PLANE_HEIGHT = DIM_W'(1024);
    localparam logic [DIM_W-1:0]  RST_PLANE_WIDTH  = DIM_W'(1024);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_SYNC_START,
        ST_SYNC
    } state_t;

endpackage
`default_nettype wire

// ===== src/mp2d_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_in_if
// Sample channel: one feature-map sample per transfer.
// ----------------------------------------------------------------------------
interface mp2d_in_if #(
    parameter int DW = mp2d_pkg::DEF_DATA_WIDTH
);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] sample;
    logic                 plane_start;

    modport source (output valid, output sample, output plane_start, input ready);
    modport sink   (input valid, input sample, input plane_start, output ready);
endinterface
`default_nettype wire

// ===== src/mp2d_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_out_if
// Result channel: one window maximum with its position per transfer.
// ----------------------------------------------------------------------------
interface mp2d_out_if #(
    parameter int DW = mp2d_pkg::DEF_DATA_WIDTH
);
    import mp2d_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] window_max;
    logic [OUT_IDX_W-1:0] out_row;
    logic [OUT_IDX_W-1:0] out_col;
    logic                 plane_last;

    modport source (output valid, output window_max, output out_row, output out_col,
                    output plane_last, input ready);
    modport sink   (input valid, input window_max, input out_row, input out_col,
                    input plane_last, output ready);
endinterface
`default_nettype wire

// ===== src/mp2d_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_cfg_if
// Configuration write channel: register index and write data per transfer.
// ----------------------------------------------------------------------------
interface mp2d_cfg_if;
    import mp2d_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/mp2d_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mp2d_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mp2d_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== src/max_pool_2d_forward.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// max_pool_2d_forward
// 2-D max pooling over feature-map planes streamed in raster order.
// samples: one signed Q8.8 sample per transfer, plane_start marks row 0, col 0.
// results: window maximum with output row, column and a last-window flag.
// cfg: register writes (0 window size, 1 step, 2 height, 3 width), taken only
//   while the block is idle; other indexes are ignored.
// a sample that closes a window is written, then its window_size^2 stored
//   samples are read through the single read port of the row store (one stored
//   sample read per cycle); the next sample waits until the result is formed.
// after each register write the position counters are rebuilt from row 0,
//   column 0, one row and one column step per cycle; samples wait meanwhile.
// reset: registers to 2, 2, 1024, 1024, position to row 0, column 0; the row
//   store is not cleared and needs no clearing pass.
// a finished result waits in an output register while the next sample is
//   taken; a stalled receiver holds the next window in its final cycle.
// ----------------------------------------------------------------------------
module max_pool_2d_forward #(
    parameter int MAX_WIDTH  = mp2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_POOL   = mp2d_pkg::DEF_MAX_POOL,
    parameter int DATA_WIDTH = mp2d_pkg::DEF_DATA_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    mp2d_in_if.sink    samples,
    mp2d_out_if.source results,
    mp2d_cfg_if.sink   cfg
);
    import mp2d_pkg::*;

    localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
    localparam int SLOT_W    = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int WIN_W     = $clog2(MAX_POOL + 1);
    localparam int WR_W      = (CNT_W > DIM_W) ? CNT_W : DIM_W;
    localparam int CMP_W     = WR_W + 2;
    localparam int MEM_DEPTH = MAX_POOL * (2 ** COL_W);
    localparam int A_W       = $clog2(MEM_DEPTH);

    // configuration
    logic [STEP_W-1:0] win_size_reg, win_size_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIM_W-1:0]  height_reg, height_next;
    logic [DIM_W-1:0]  width_reg, width_next;

    logic [WIN_W-1:0]  win;
    logic [STEP_W-1:0] stp;
    logic [DIM_W-1:0]  hgt;
    logic [CNT_W-1:0]  wid;
    logic [WR_W-1:0]   width_ext;
    logic [CMP_W-1:0]  wn, ht, wd, sp;

    state_t state_reg, state_next;

    // position counters
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [STEP_W-1:0] rmod_reg, rmod_next;
    logic [ROW_W-1:0]  rq_reg, rq_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [STEP_W-1:0] cmod_reg, cmod_next;
    logic [COL_W-1:0]  cq_reg, cq_next;
    logic [ROW_W-1:0]  tgt_row_reg, tgt_row_next;
    logic [COL_W-1:0]  tgt_col_reg, tgt_col_next;
    logic [ROW_W-1:0]  pos_row_reg, pos_row_next;
    logic [COL_W-1:0]  pos_col_reg, pos_col_next;

    // window scan
    logic [SLOT_W-1:0]            i_reg, i_next;
    logic [SLOT_W-1:0]            j_reg, j_next;
    logic [COL_W-1:0]             cb_reg, cb_next;
    logic [ROW_W-1:0]             oh_reg, oh_next;
    logic [COL_W-1:0]             ow_reg, ow_next;
    logic                         wlast_reg, wlast_next;
    logic signed [DATA_WIDTH-1:0] best_reg, best_next;
    logic                         first_reg, first_next;
    logic                         rd_pending_reg, rd_pending_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic signed [DATA_WIDTH-1:0] max_reg, max_next;
    logic [OUT_IDX_W-1:0]         orow_reg, orow_next;
    logic [OUT_IDX_W-1:0]         ocol_reg, ocol_next;
    logic                         olast_reg, olast_next;

    // row store
    logic                  ram_we;
    logic [A_W-1:0]        ram_waddr;
    logic [A_W-1:0]        ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic signed [DATA_WIDTH-1:0] rd_s;
    logic signed [DATA_WIDTH-1:0] best_cur;

    // position sources and their advance
    logic              use_zero;
    logic [ROW_W-1:0]  r_src, rq_src, r_inc, rq_inc;
    logic [SLOT_W-1:0] slot_src, slot_inc;
    logic [STEP_W-1:0] rmod_src, rmod_inc, cmod_src, cmod_inc;
    logic [COL_W-1:0]  c_src, cq_src, c_inc, cq_inc;

    logic             close_win, win_last, col_end, row_end;
    logic [COL_W-1:0] cb;
    logic             col_wrap;
    logic [CMP_W-1:0] r1;
    logic [ROW_W-1:0] r_t;
    logic [COL_W-1:0] c_t;

    logic in_ready, cfg_ready, out_free, last_read;

    mp2d_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MEM_DEPTH)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (DATA_WIDTH'(samples.sample)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // effective register values
    always_comb
    begin
        if (win_size_reg == '0)
        begin
            win = WIN_W'(1);
        end
        else if ({1'b0, win_size_reg} > (STEP_W + 1)'(MAX_POOL))
        begin
            win = WIN_W'(MAX_POOL);
        end
        else
        begin
            win = WIN_W'(win_size_reg);
        end

        stp = (step_reg == '0) ? STEP_W'(1) : step_reg;

        if (height_reg == '0)
        begin
            hgt = DIM_W'(1);
        end
        else if (height_reg > DIM_W'(HEIGHT_LIMIT))
        begin
            hgt = DIM_W'(HEIGHT_LIMIT);
        end
        else
        begin
            hgt = height_reg;
        end

        width_ext = WR_W'(width_reg);
        if (width_ext == '0)
        begin
            wid = CNT_W'(1);
        end
        else if (width_ext > WR_W'(MAX_WIDTH))
        begin
            wid = CNT_W'(MAX_WIDTH);
        end
        else
        begin
            wid = CNT_W'(width_ext);
        end
    end

    assign wn = CMP_W'(win);
    assign ht = CMP_W'(hgt);
    assign wd = CMP_W'(wid);
    assign sp = CMP_W'(stp);

    // a plane start puts the sample at row 0, column 0
    assign use_zero = (state_reg == ST_IDLE) && samples.plane_start;
    assign r_src    = use_zero ? '0 : row_reg;
    assign slot_src = use_zero ? '0 : slot_reg;
    assign rmod_src = use_zero ? '0 : rmod_reg;
    assign rq_src   = use_zero ? '0 : rq_reg;
    assign c_src    = use_zero ? '0 : col_reg;
    assign cmod_src = use_zero ? '0 : cmod_reg;
    assign cq_src   = use_zero ? '0 : cq_reg;

    // one row and one column step
    always_comb
    begin
        r_inc    = r_src + ROW_W'(1);
        slot_inc = ((WIN_W'(slot_src) + WIN_W'(1)) == win) ? '0 : slot_src + SLOT_W'(1);
        if ((CMP_W'(r_inc) + CMP_W'(1)) <= wn)
        begin
            rmod_inc = '0;
            rq_inc   = '0;
        end
        else if ((rmod_src + STEP_W'(1)) == stp)
        begin
            rmod_inc = '0;
            rq_inc   = rq_src + ROW_W'(1);
        end
        else
        begin
            rmod_inc = rmod_src + STEP_W'(1);
            rq_inc   = rq_src;
        end

        c_inc = c_src + COL_W'(1);
        if ((CMP_W'(c_inc) + CMP_W'(1)) <= wn)
        begin
            cmod_inc = '0;
            cq_inc   = '0;
        end
        else if ((cmod_src + STEP_W'(1)) == stp)
        begin
            cmod_inc = '0;
            cq_inc   = cq_src + COL_W'(1);
        end
        else
        begin
            cmod_inc = cmod_src + STEP_W'(1);
            cq_inc   = cq_src;
        end
    end

    assign close_win = (wn <= ht) && (wn <= wd)
                    && ((CMP_W'(r_src) + CMP_W'(1)) >= wn)
                    && ((CMP_W'(c_src) + CMP_W'(1)) >= wn)
                    && (rmod_src == '0) && (cmod_src == '0);
    assign win_last  = ((CMP_W'(r_src) + CMP_W'(1) + sp) > ht)
                    && ((CMP_W'(c_src) + CMP_W'(1) + sp) > wd);
    assign col_end   = (CMP_W'(c_src) + CMP_W'(1)) >= wd;
    assign row_end   = (CMP_W'(r_src) + CMP_W'(1)) >= ht;
    assign cb        = COL_W'(CMP_W'(c_src) + CMP_W'(1) - wn);

    // position left by the last sample, wrapped into the plane as now set
    assign col_wrap = CMP_W'(pos_col_reg) >= wd;
    assign c_t      = col_wrap ? '0 : pos_col_reg;
    assign r1       = CMP_W'(pos_row_reg) + (col_wrap ? CMP_W'(1) : CMP_W'(0));
    assign r_t      = (r1 >= ht) ? '0 : ROW_W'(r1);

    assign rd_s     = $signed(ram_rdata);
    assign best_cur = (rd_pending_reg && (first_reg || (rd_s > best_reg))) ? rd_s : best_reg;
    assign out_free = !out_valid_reg || results.ready;
    assign last_read = ((WIN_W'(i_reg) + WIN_W'(1)) == win)
                    && ((WIN_W'(j_reg) + WIN_W'(1)) == win);

    always_comb
    begin
        state_next      = state_reg;
        win_size_next   = win_size_reg;
        step_next       = step_reg;
        height_next     = height_reg;
        width_next      = width_reg;
        row_next        = row_reg;
        slot_next       = slot_reg;
        rmod_next       = rmod_reg;
        rq_next         = rq_reg;
        col_next        = col_reg;
        cmod_next       = cmod_reg;
        cq_next         = cq_reg;
        tgt_row_next    = tgt_row_reg;
        tgt_col_next    = tgt_col_reg;
        pos_row_next    = pos_row_reg;
        pos_col_next    = pos_col_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        cb_next         = cb_reg;
        oh_next         = oh_reg;
        ow_next         = ow_reg;
        wlast_next      = wlast_reg;
        best_next       = best_reg;
        first_next      = first_reg;
        rd_pending_next = 1'b0;
        out_valid_next  = out_valid_reg && !results.ready;
        max_next        = max_reg;
        orow_next       = orow_reg;
        ocol_next       = ocol_reg;
        olast_next      = olast_reg;
        ram_we          = 1'b0;
        ram_waddr       = A_W'({slot_src, c_src});
        ram_raddr       = A_W'({i_reg, COL_W'(cb_reg + COL_W'(j_reg))});
        in_ready        = 1'b0;
        cfg_ready       = 1'b0;

        if (rd_pending_reg)
        begin
            best_next  = best_cur;
            first_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                cfg_ready = 1'b1;
                in_ready  = !cfg.valid;
                if (cfg.valid)
                begin
                    case (cfg.index)
                        REG_WINDOW_SIZE:  win_size_next = cfg.data[STEP_W-1:0];
                        REG_STEP_SIZE:    step_next     = cfg.data[STEP_W-1:0];
                        REG_PLANE_HEIGHT: height_next   = cfg.data[DIM_W-1:0];
                        REG_PLANE_WIDTH:  width_next    = cfg.data[DIM_W-1:0];
                        default:          ;
                    endcase
                    state_next = ST_SYNC_START;
                end
                else if (samples.valid)
                begin
                    ram_we     = 1'b1;
                    oh_next    = rq_src;
                    ow_next    = cq_src;
                    wlast_next = win_last;
                    cb_next    = cb;
                    i_next     = '0;
                    j_next     = '0;
                    first_next = 1'b1;
                    if (close_win)
                    begin
                        state_next = ST_READ;
                    end
                    if (col_end)
                    begin
                        col_next  = '0;
                        cmod_next = '0;
                        cq_next   = '0;
                        if (row_end)
                        begin
                            row_next  = '0;
                            slot_next = '0;
                            rmod_next = '0;
                            rq_next   = '0;
                        end
                        else
                        begin
                            row_next  = r_inc;
                            slot_next = slot_inc;
                            rmod_next = rmod_inc;
                            rq_next   = rq_inc;
                        end
                    end
                    else
                    begin
                        col_next  = c_inc;
                        cmod_next = cmod_inc;
                        cq_next   = cq_inc;
                        row_next  = r_src;
                        slot_next = slot_src;
                        rmod_next = rmod_src;
                        rq_next   = rq_src;
                    end
                    pos_row_next = row_next;
                    pos_col_next = col_next;
                end
            end

            ST_READ:
            begin
                rd_pending_next = 1'b1;
                if ((WIN_W'(j_reg) + WIN_W'(1)) == win)
                begin
                    j_next = '0;
                    i_next = i_reg + SLOT_W'(1);
                end
                else
                begin
                    j_next = j_reg + SLOT_W'(1);
                end
                if (last_read)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    max_next       = best_cur;
                    orow_next      = OUT_IDX_W'(oh_reg);
                    ocol_next      = OUT_IDX_W'(ow_reg);
                    olast_next     = wlast_reg;
                    state_next     = ST_IDLE;
                end
            end

            ST_SYNC_START:
            begin
                tgt_row_next = r_t;
                tgt_col_next = c_t;
                row_next     = '0;
                slot_next    = '0;
                rmod_next    = '0;
                rq_next      = '0;
                col_next     = '0;
                cmod_next    = '0;
                cq_next      = '0;
                state_next   = ST_SYNC;
            end

            ST_SYNC:
            begin
                if (row_reg != tgt_row_reg)
                begin
                    row_next  = r_inc;
                    slot_next = slot_inc;
                    rmod_next = rmod_inc;
                    rq_next   = rq_inc;
                end
                if (col_reg != tgt_col_reg)
                begin
                    col_next  = c_inc;
                    cmod_next = cmod_inc;
                    cq_next   = cq_inc;
                end
                if ((row_reg == tgt_row_reg) && (col_reg == tgt_col_reg))
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_size_reg   <= RST_WINDOW_SIZE;
            step_reg       <= RST_STEP_SIZE;
            height_reg     <= RST_PLANE_HEIGHT;
            width_reg      <= RST_PLANE_WIDTH;
            row_reg        <= '0;
            slot_reg       <= '0;
            rmod_reg       <= '0;
            rq_reg         <= '0;
            col_reg        <= '0;
            cmod_reg       <= '0;
            cq_reg         <= '0;
            tgt_row_reg    <= '0;
            tgt_col_reg    <= '0;
            pos_row_reg    <= '0;
            pos_col_reg    <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            first_reg      <= 1'b0;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            win_size_reg   <= win_size_next;
            step_reg       <= step_next;
            height_reg     <= height_next;
            width_reg      <= width_next;
            row_reg        <= row_next;
            slot_reg       <= slot_next;
            rmod_reg       <= rmod_next;
            rq_reg         <= rq_next;
            col_reg        <= col_next;
            cmod_reg       <= cmod_next;
            cq_reg         <= cq_next;
            tgt_row_reg    <= tgt_row_next;
            tgt_col_reg    <= tgt_col_next;
            pos_row_reg    <= pos_row_next;
            pos_col_reg    <= pos_col_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            first_reg      <= first_next;
            rd_pending_reg <= rd_pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cb_reg    <= cb_next;
        oh_reg    <= oh_next;
        ow_reg    <= ow_next;
        wlast_reg <= wlast_next;
        best_reg  <= best_next;
        max_reg   <= max_next;
        orow_reg  <= orow_next;
        ocol_reg  <= ocol_next;
        olast_reg <= olast_next;
    end

    assign samples.ready      = in_ready;
    assign cfg.ready          = cfg_ready;
    assign results.valid      = out_valid_reg;
    assign results.window_max = max_reg;
    assign results.out_row    = orow_reg;
    assign results.out_col    = ocol_reg;
    assign results.plane_last = olast_reg;

    // position stays inside the plane whenever a sample can be taken
    a_pos_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((CMP_W'(row_reg) < ht) && (CMP_W'(col_reg) < wd)))
        else $error("position outside plane while idle");

    // row slot and step phases agree with the current registers
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((WIN_W'(slot_reg) < win) && (rmod_reg < stp)
                                    && (cmod_reg < stp)))
        else $error("row slot or step phase out of range");

    // a result is only formed after a window scan
    a_emit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (($past(state_reg) == ST_READ)
                                    || ($past(state_reg) == ST_EMIT)))
        else $error("result stage entered without a window scan");

    // store read data is only consumed right after a scan cycle
    a_read_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pending_reg |-> ((state_reg == ST_READ) || (state_reg == ST_EMIT)))
        else $error("store read data outside a window scan");

endmodule
`default_nettype wire
